// ===== rtl/marker_length_frame_decoder_assert.svh =====
// Assertion macros shared by the frame decoder RTL.
`ifndef MARKER_LENGTH_FRAME_DECODER_ASSERT_SVH
`define MARKER_LENGTH_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MLFD_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MLFD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/mlfd_pkg.sv =====
// Types and constants shared by the marker/length frame decoder modules.
package mlfd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] START_ONE_RESET = 8'd170;
    localparam logic [7:0] START_TWO_RESET = 8'd85;
    localparam logic [7:0] END_ONE_RESET   = 8'd85;
    localparam logic [7:0] END_TWO_RESET   = 8'd170;

    typedef enum logic [1:0] {
        CFG_START_ONE = 2'd0,
        CFG_START_TWO = 2'd1,
        CFG_END_ONE   = 2'd2,
        CFG_END_TWO   = 2'd3
    } mlfd_cfg_t;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_LEN_LO   = 3'd1,
        PH_LEN_HI   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_END1     = 3'd4,
        PH_END2     = 3'd5,
        PH_END2_BAD = 3'd6,
        PH_DONE     = 3'd7
    } mlfd_phase_t;

    typedef enum logic [2:0] {
        VERDICT_GOOD       = 3'd0,
        VERDICT_BAD_LENGTH = 3'd1,
        VERDICT_TRUNCATED  = 3'd2,
        VERDICT_BAD_END    = 3'd3,
        VERDICT_NO_START   = 3'd4
    } mlfd_verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } mlfd_kind_t;

    typedef struct packed {
        mlfd_kind_t    kind;
        logic [7:0]    payload;
        mlfd_verdict_t verdict;
        logic          done;
    } mlfd_result_t;

    typedef struct packed {
        logic full;
        logic valid;
    } mlfd_q_stat_t;

endpackage

// ===== rtl/mlfd_front.sv =====
// Front end: marker registers, frame phase tracking and result classification.
module mlfd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  mlfd_pkg::mlfd_q_stat_t q_stat,
    output logic                  push,
    output mlfd_pkg::mlfd_result_t push_data
);

    logic [7:0] start_one_reg;
    logic [7:0] start_two_reg;
    logic [7:0] end_one_reg;
    logic [7:0] end_two_reg;

    mlfd_pkg::mlfd_phase_t phase_reg, phase_next;
    logic        prev_one_reg, prev_one_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [14:0] remaining_reg, remaining_next;

    logic       accept;
    logic       bad_length;
    logic       res_valid;
    logic [7:0] data_byte;
    logic       last;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign data_byte     = s_axis_tdata;
    assign last          = s_axis_tlast;
    assign bad_length    = data_byte[7] || ((data_byte == 8'd0) && (len_lo_reg == 8'd0));
    assign push          = accept && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_one_reg <= mlfd_pkg::START_ONE_RESET;
            start_two_reg <= mlfd_pkg::START_TWO_RESET;
            end_one_reg   <= mlfd_pkg::END_ONE_RESET;
            end_two_reg   <= mlfd_pkg::END_TWO_RESET;
        end
        else if (cfg_we)
        begin
            case (mlfd_pkg::mlfd_cfg_t'(cfg_index))
                mlfd_pkg::CFG_START_ONE: start_one_reg <= cfg_data;
                mlfd_pkg::CFG_START_TWO: start_two_reg <= cfg_data;
                mlfd_pkg::CFG_END_ONE:   end_one_reg   <= cfg_data;
                mlfd_pkg::CFG_END_TWO:   end_two_reg   <= cfg_data;
                default:                 start_one_reg <= start_one_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mlfd_pkg::PH_HUNT;
            prev_one_reg  <= 1'b0;
            len_lo_reg    <= 8'd0;
            remaining_reg <= 15'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_one_reg  <= prev_one_next;
            len_lo_reg    <= len_lo_next;
            remaining_reg <= remaining_next;
        end
    end

    // Every phase returns to hunting with cleared state on the last byte.
    always_comb
    begin
        phase_next     = phase_reg;
        prev_one_next  = prev_one_reg;
        len_lo_next    = len_lo_reg;
        remaining_next = remaining_reg;
        if (accept)
        begin
            case (phase_reg)
                mlfd_pkg::PH_HUNT:
                begin
                    if (prev_one_reg && (data_byte == start_two_reg))
                    begin
                        prev_one_next = 1'b0;
                        phase_next    = mlfd_pkg::PH_LEN_LO;
                    end
                    else
                    begin
                        prev_one_next = (data_byte == start_one_reg);
                    end
                end
                mlfd_pkg::PH_LEN_LO:
                begin
                    len_lo_next = data_byte;
                    phase_next  = mlfd_pkg::PH_LEN_HI;
                end
                mlfd_pkg::PH_LEN_HI:
                begin
                    if (bad_length)
                    begin
                        phase_next = mlfd_pkg::PH_DONE;
                    end
                    else
                    begin
                        remaining_next = {data_byte[6:0], len_lo_reg};
                        phase_next     = mlfd_pkg::PH_PAYLOAD;
                    end
                end
                mlfd_pkg::PH_PAYLOAD:
                begin
                    remaining_next = remaining_reg - 15'd1;
                    if (remaining_reg == 15'd1)
                    begin
                        phase_next = mlfd_pkg::PH_END1;
                    end
                end
                mlfd_pkg::PH_END1:
                begin
                    phase_next = (data_byte == end_one_reg) ? mlfd_pkg::PH_END2
                                                            : mlfd_pkg::PH_END2_BAD;
                end
                mlfd_pkg::PH_END2:     phase_next = mlfd_pkg::PH_DONE;
                mlfd_pkg::PH_END2_BAD: phase_next = mlfd_pkg::PH_DONE;
                mlfd_pkg::PH_DONE:     phase_next = mlfd_pkg::PH_DONE;
                default:               phase_next = mlfd_pkg::PH_HUNT;
            endcase
            if (last)
            begin
                phase_next     = mlfd_pkg::PH_HUNT;
                prev_one_next  = 1'b0;
                len_lo_next    = 8'd0;
                remaining_next = 15'd0;
            end
        end
    end

    always_comb
    begin
        res_valid         = 1'b0;
        push_data.kind    = mlfd_pkg::KIND_VERDICT;
        push_data.payload = 8'd0;
        push_data.verdict = mlfd_pkg::VERDICT_GOOD;
        push_data.done    = 1'b1;
        case (phase_reg)
            mlfd_pkg::PH_HUNT:
            begin
                res_valid         = last;
                push_data.verdict = mlfd_pkg::VERDICT_NO_START;
            end
            mlfd_pkg::PH_LEN_LO:
            begin
                res_valid         = last;
                push_data.verdict = mlfd_pkg::VERDICT_TRUNCATED;
            end
            mlfd_pkg::PH_LEN_HI:
            begin
                res_valid         = bad_length || last;
                push_data.verdict = bad_length ? mlfd_pkg::VERDICT_BAD_LENGTH
                                               : mlfd_pkg::VERDICT_TRUNCATED;
            end
            mlfd_pkg::PH_PAYLOAD:
            begin
                res_valid = 1'b1;
                if (last)
                begin
                    push_data.verdict = mlfd_pkg::VERDICT_TRUNCATED;
                end
                else
                begin
                    push_data.kind    = mlfd_pkg::KIND_PAYLOAD;
                    push_data.payload = data_byte;
                    push_data.done    = 1'b0;
                end
            end
            mlfd_pkg::PH_END1:
            begin
                res_valid         = last;
                push_data.verdict = mlfd_pkg::VERDICT_TRUNCATED;
            end
            mlfd_pkg::PH_END2:
            begin
                res_valid         = 1'b1;
                push_data.verdict = (data_byte == end_two_reg) ? mlfd_pkg::VERDICT_GOOD
                                                               : mlfd_pkg::VERDICT_BAD_END;
            end
            mlfd_pkg::PH_END2_BAD:
            begin
                res_valid         = 1'b1;
                push_data.verdict = mlfd_pkg::VERDICT_BAD_END;
            end
            mlfd_pkg::PH_DONE: res_valid = 1'b0;
            default:           res_valid = 1'b0;
        endcase
    end

endmodule

// ===== rtl/mlfd_queue.sv =====
// Result queue between the classifying front end and the output stage.
module mlfd_queue #(
    parameter int Depth = mlfd_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mlfd_pkg::mlfd_result_t push_data,
    input  logic                   pop,
    output mlfd_pkg::mlfd_result_t pop_data,
    output mlfd_pkg::mlfd_q_stat_t q_stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    mlfd_pkg::mlfd_result_t mem_reg [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign q_stat.full  = (count_reg == CntW'(Depth));
    assign q_stat.valid = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mlfd_back.sv =====
// Output stage: registers queued results onto the master stream.
module mlfd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mlfd_pkg::mlfd_q_stat_t q_stat,
    input  mlfd_pkg::mlfd_result_t pop_data,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [15:0]            m_axis_tdata,
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic                   valid_reg, valid_next;
    mlfd_pkg::mlfd_result_t data_reg;
    logic                   load;

    assign load = q_stat.valid && (!valid_reg || m_axis_tready);
    assign pop  = load;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= pop_data;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'd0, data_reg.verdict, data_reg.payload};
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.done;

endmodule

// ===== rtl/marker_length_frame_decoder.sv =====
// Top level of the marker/length frame decoder: front end, result queue and output stage.
//
//   Channel   Dir  Contents
//   s_axis    in   tdata: data_byte[7:0]; tlast: datagram_end
//   m_axis    out  tdata: payload_byte[7:0], verdict[10:8]; tuser: result_kind;
//                  tlast: frame_done
//   cfg       in   cfg_we, cfg_index (register number), cfg_data (8-bit value)
//
// One byte is accepted every cycle while the result queue has room; a result passes through the
// queue and the output register before it appears on m_axis. The front end updates the frame phase once per byte.
// Reset clears the phase, the queue and the output stage and loads the default markers.
// s_axis_tready drops only while the result queue of QueueDepth entries is full.
// A stalled m_axis fills the queue first; bytes that give no result still need a free slot.
module marker_length_frame_decoder #(
    parameter int QueueDepth = mlfd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // payload_byte[7:0], verdict[10:8], zero[15:11]
    output logic        m_axis_tuser,    // result_kind[0]
    output logic        m_axis_tlast
);

    `include "marker_length_frame_decoder_assert.svh"

    mlfd_pkg::mlfd_q_stat_t q_stat;
    mlfd_pkg::mlfd_result_t push_data;
    mlfd_pkg::mlfd_result_t pop_data;
    logic                   push;
    logic                   pop;

    mlfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    mlfd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    mlfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_data      (pop_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `MLFD_ASSERT_NOW(a_push_has_room, push, !q_stat.full, "result pushed into a full queue")

    `MLFD_ASSERT_NEXT(a_output_fills, q_stat.valid && !m_axis_tvalid, m_axis_tvalid,
        "queued result not moved to an empty output stage")

    `MLFD_ASSERT_NOW(a_payload_fields, m_axis_tvalid && (m_axis_tuser == 1'b0),
        !m_axis_tlast && (m_axis_tdata[10:8] == 3'd0), "payload beat carries verdict fields")

endmodule

// ===== dv/marker_length_frame_decoder_tb.sv =====
// Self-checking testbench for the marker/length frame decoder with a built-in frame predictor.
`timescale 1ns / 1ps

module marker_length_frame_decoder_tb;

    localparam int     HOLD_OFF_CYCLES = 120;
    localparam int     DRAIN_LIMIT     = 20000;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     MAX_PRINTS      = 30;
    localparam longint TIMEOUT_NS      = 3_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = mlfd_pkg::CFG_START_ONE;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // data_byte[7:0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // payload_byte[7:0], verdict[10:8], zero[15:11]
    logic        m_axis_tuser;            // result_kind[0]
    logic        m_axis_tlast;

    rx_byte_t               bytes_to_send [$];
    mlfd_pkg::mlfd_result_t results_due [$];

    // Shadow copy of the marker registers and of the frame state.
    logic [7:0]            marker [4];
    mlfd_pkg::mlfd_phase_t frame_phase;
    logic                  start_one_seen;
    logic [7:0]            length_low;
    logic [14:0]           payload_left;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    int error_count = 0;
    int bytes_accepted = 0;
    int datagrams_queued = 0;
    int payload_beats = 0;
    int verdict_tally [5] = '{0, 0, 0, 0, 0};

    marker_length_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still due.", results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTS)
            $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void restart_hunt();
        frame_phase    = mlfd_pkg::PH_HUNT;
        start_one_seen = 1'b0;
        length_low     = 8'h00;
        payload_left   = 15'd0;
    endfunction

    function automatic void close_frame(input mlfd_pkg::mlfd_verdict_t v, input logic last);
        mlfd_pkg::mlfd_result_t r;
        r.kind    = mlfd_pkg::KIND_VERDICT;
        r.payload = 8'h00;
        r.verdict = v;
        r.done    = 1'b1;
        results_due.push_back(r);
        if (last)
            restart_hunt();
        else
            frame_phase = mlfd_pkg::PH_DONE;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        mlfd_pkg::mlfd_result_t r;
        case (frame_phase)
            mlfd_pkg::PH_HUNT:
            begin
                if (start_one_seen && b == marker[mlfd_pkg::CFG_START_TWO])
                begin
                    start_one_seen = 1'b0;
                    frame_phase    = mlfd_pkg::PH_LEN_LO;
                end
                else
                    start_one_seen = (b == marker[mlfd_pkg::CFG_START_ONE]);
                if (last)
                    close_frame(mlfd_pkg::VERDICT_NO_START, 1'b1);
            end
            mlfd_pkg::PH_LEN_LO:
            begin
                length_low = b;
                if (last)
                    close_frame(mlfd_pkg::VERDICT_TRUNCATED, 1'b1);
                else
                    frame_phase = mlfd_pkg::PH_LEN_HI;
            end
            mlfd_pkg::PH_LEN_HI:
            begin
                if (b[7] || (b == 8'h00 && length_low == 8'h00))
                    close_frame(mlfd_pkg::VERDICT_BAD_LENGTH, last);
                else if (last)
                    close_frame(mlfd_pkg::VERDICT_TRUNCATED, 1'b1);
                else
                begin
                    payload_left = {b[6:0], length_low};
                    frame_phase  = mlfd_pkg::PH_PAYLOAD;
                end
            end
            mlfd_pkg::PH_PAYLOAD:
            begin
                if (last)
                    close_frame(mlfd_pkg::VERDICT_TRUNCATED, 1'b1);
                else
                begin
                    r.kind    = mlfd_pkg::KIND_PAYLOAD;
                    r.payload = b;
                    r.verdict = mlfd_pkg::VERDICT_GOOD;
                    r.done    = 1'b0;
                    results_due.push_back(r);
                    payload_left = payload_left - 15'd1;
                    if (payload_left == 15'd0)
                        frame_phase = mlfd_pkg::PH_END1;
                end
            end
            mlfd_pkg::PH_END1:
            begin
                if (last)
                    close_frame(mlfd_pkg::VERDICT_TRUNCATED, 1'b1);
                else if (b == marker[mlfd_pkg::CFG_END_ONE])
                    frame_phase = mlfd_pkg::PH_END2;
                else
                    frame_phase = mlfd_pkg::PH_END2_BAD;
            end
            mlfd_pkg::PH_END2:
            begin
                if (b == marker[mlfd_pkg::CFG_END_TWO])
                    close_frame(mlfd_pkg::VERDICT_GOOD, last);
                else
                    close_frame(mlfd_pkg::VERDICT_BAD_END, last);
            end
            mlfd_pkg::PH_END2_BAD:
                close_frame(mlfd_pkg::VERDICT_BAD_END, last);
            default:
            begin
                if (last)
                    restart_hunt();
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : sender
        rx_byte_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : receiver
        mlfd_pkg::mlfd_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result beat", int'(m_axis_tdata), 0);
                else
                begin
                    want = results_due.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("result_kind", int'(m_axis_tuser), int'(want.kind));
                    if (m_axis_tdata[7:0] !== want.payload)
                        report_mismatch("payload_byte", int'(m_axis_tdata[7:0]),
                                        int'(want.payload));
                    if (m_axis_tdata[10:8] !== want.verdict)
                        report_mismatch("verdict", int'(m_axis_tdata[10:8]),
                                        int'(want.verdict));
                    if (m_axis_tlast !== want.done)
                        report_mismatch("frame_done", int'(m_axis_tlast), int'(want.done));
                    if (m_axis_tdata[15:11] !== 5'd0)
                        report_mismatch("tdata padding", int'(m_axis_tdata[15:11]), 0);
                    if (want.kind == mlfd_pkg::KIND_PAYLOAD)
                        payload_beats++;
                    else
                        verdict_tally[want.verdict]++;
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Long receiver hold-off so that the result queue fills and the input stalls.
    initial
    begin : receiver_hold_off
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_datagram(input logic [7:0] dg [$]);
        rx_byte_t item;
        @(negedge clk);
        foreach (dg[i])
        begin
            item.data = dg[i];
            item.last = (i == dg.size() - 1);
            bytes_to_send.push_back(item);
        end
        datagrams_queued++;
    endtask

    task automatic queue_random_datagram(output int n_bytes);
        logic [7:0] dg [$];
        int kind_pick;
        int len;
        int cut;
        logic [7:0] noise;
        kind_pick = $urandom_range(99);
        repeat ($urandom_range(0, 3))
        begin
            noise = 8'($urandom_range(255));
            if (noise == marker[mlfd_pkg::CFG_START_ONE])
                noise = noise ^ 8'h01;
            dg.push_back(noise);
        end
        if (kind_pick >= 90)
        begin
            repeat ($urandom_range(1, 12))
                dg.push_back(8'($urandom_range(255)));
        end
        else
        begin
            dg.push_back(marker[mlfd_pkg::CFG_START_ONE]);
            dg.push_back(marker[mlfd_pkg::CFG_START_TWO]);
            if ($urandom_range(39) == 0)
                len = 32'h0000_7FFF;
            else if ($urandom_range(24) == 0)
                len = $urandom_range(9, 300);
            else
                len = $urandom_range(1, 8);
            if (kind_pick >= 60 && kind_pick < 68)
            begin
                if ($urandom_range(1))
                begin
                    dg.push_back(8'h00);
                    dg.push_back(8'h00);
                end
                else
                begin
                    dg.push_back(8'($urandom_range(255)));
                    dg.push_back(8'h80 | 8'($urandom_range(127)));
                end
                len = $urandom_range(0, 4);
            end
            else
            begin
                dg.push_back(len[7:0]);
                dg.push_back({1'b0, len[14:8]});
            end
            if (len == 32'h0000_7FFF)
                len = $urandom_range(3, 10);
            repeat (len)
                dg.push_back(8'($urandom_range(255)));
            dg.push_back(kind_pick >= 76 && kind_pick < 84 ?
                         marker[mlfd_pkg::CFG_END_ONE] ^ 8'($urandom_range(1, 255)) :
                         marker[mlfd_pkg::CFG_END_ONE]);
            dg.push_back(kind_pick >= 84 && kind_pick < 90 ?
                         marker[mlfd_pkg::CFG_END_TWO] ^ 8'($urandom_range(1, 255)) :
                         marker[mlfd_pkg::CFG_END_TWO]);
            repeat ($urandom_range(0, 2))
                dg.push_back(8'($urandom_range(255)));
            if (kind_pick >= 68 && kind_pick < 76)
            begin
                cut = $urandom_range(0, dg.size() - 1);
                while (dg.size() > cut + 1)
                    void'(dg.pop_back());
            end
        end
        n_bytes = dg.size();
        queue_datagram(dg);
    endtask

    task automatic queue_random_traffic(input int target_bytes);
        int added;
        int n;
        added = 0;
        while (added < target_bytes)
        begin
            queue_random_datagram(n);
            added += n;
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(negedge clk);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    task automatic wait_until_drained();
        int n;
        n = 0;
        do
        begin
            @(negedge clk);
            n++;
        end
        while ((bytes_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
               && n < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_marker(input mlfd_pkg::mlfd_cfg_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        marker[idx] = value;
    endtask

    task automatic run_directed();
        logic [7:0] dg [$];
        dg = {8'hAA, 8'h55, 8'h01, 8'h00, 8'hFF, 8'h55, 8'hAA};
        queue_datagram(dg);
        // Overlapping start bytes, zero length, then a trailing byte ignored until the datagram ends.
        dg = {8'hAA, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h13};
        queue_datagram(dg);
        dg = {8'hAA, 8'h55, 8'h02, 8'h80};
        queue_datagram(dg);
        dg = {8'hAA, 8'h55};
        queue_datagram(dg);
        dg = {8'hAA, 8'h55, 8'h07};
        queue_datagram(dg);
        dg = {8'hAA, 8'h55, 8'hFF, 8'h7F, 8'h00, 8'h5A};
        queue_datagram(dg);
        dg = {8'hAA, 8'h55, 8'h01, 8'h00, 8'h3C, 8'h7E, 8'hAA};
        queue_datagram(dg);
        dg = {8'hAA, 8'h55, 8'h01, 8'h00, 8'hC3, 8'h7E};
        queue_datagram(dg);
    endtask

    initial
    begin : stimulus
        marker[mlfd_pkg::CFG_START_ONE] = mlfd_pkg::START_ONE_RESET;
        marker[mlfd_pkg::CFG_START_TWO] = mlfd_pkg::START_TWO_RESET;
        marker[mlfd_pkg::CFG_END_ONE]   = mlfd_pkg::END_ONE_RESET;
        marker[mlfd_pkg::CFG_END_TWO]   = mlfd_pkg::END_TWO_RESET;
        restart_hunt();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_until_drained();

        @(negedge clk);
        hold_go = 1'b1;
        queue_random_traffic(60);
        wait_until_drained();

        write_marker(mlfd_pkg::CFG_START_ONE, 8'h00);
        write_marker(mlfd_pkg::CFG_START_TWO, 8'h00);
        write_marker(mlfd_pkg::CFG_END_ONE, 8'hFF);
        write_marker(mlfd_pkg::CFG_END_TWO, 8'hFF);
        set_idling(82, 0);
        queue_random_traffic(150);
        wait_until_drained();

        write_marker(mlfd_pkg::CFG_START_ONE, 8'($urandom_range(255)));
        write_marker(mlfd_pkg::CFG_START_TWO, 8'($urandom_range(255)));
        write_marker(mlfd_pkg::CFG_END_ONE, 8'($urandom_range(255)));
        write_marker(mlfd_pkg::CFG_END_TWO, 8'($urandom_range(255)));
        set_idling(0, 82);
        queue_random_traffic(150);
        wait_until_drained();

        write_marker(mlfd_pkg::CFG_START_ONE, 8'hFF);
        write_marker(mlfd_pkg::CFG_START_TWO, 8'h00);
        write_marker(mlfd_pkg::CFG_END_ONE, 8'h00);
        write_marker(mlfd_pkg::CFG_END_TWO, 8'hFF);
        set_idling(38, 38);
        queue_random_traffic(150);
        wait_until_drained();

        write_marker(mlfd_pkg::CFG_START_ONE, mlfd_pkg::START_ONE_RESET);
        write_marker(mlfd_pkg::CFG_START_TWO, mlfd_pkg::START_TWO_RESET);
        write_marker(mlfd_pkg::CFG_END_ONE, mlfd_pkg::END_ONE_RESET);
        write_marker(mlfd_pkg::CFG_END_TWO, mlfd_pkg::END_TWO_RESET);
        set_idling(0, 0);
        queue_random_traffic(100);
        wait_until_drained();

        if (results_due.size() != 0)
            report_mismatch("results never delivered", 0, results_due.size());

        $display("Sent %0d bytes in %0d datagrams over four marker settings and four idle mixes.",
                 bytes_accepted, datagrams_queued);
        $display("Checked %0d payload beats; verdicts good %0d, length %0d, truncated %0d, %s",
                 payload_beats, verdict_tally[0], verdict_tally[1], verdict_tally[2],
                 $sformatf("end marker %0d, no start %0d.", verdict_tally[3], verdict_tally[4]));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mlfd_pkg.sv
rtl/mlfd_front.sv
rtl/mlfd_queue.sv
rtl/mlfd_back.sv
rtl/marker_length_frame_decoder.sv
dv/marker_length_frame_decoder_tb.sv
